>>> rtl/tvsd_pkg.sv
// tvsd_pkg: types and constants of the tagged value stream decoder
// no dependencies
`timescale 1ns / 1ps
package tvsd_pkg;
  localparam logic [7:0] TagInt = 8'h40;
  localparam logic [7:0] TagStr = 8'h00;
  localparam logic [7:0] TagFlt = 8'hff;
  localparam logic [10:0] ExpOffset = 11'd894;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_FLT   = 3'd1,
    KIND_CHR   = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_BAD   = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PH_TAG = 5'b00001,
    PH_INT = 5'b00010,
    PH_FLT = 5'b00100,
    PH_LEN = 5'b01000,
    PH_CHR = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [7:0]  position;
    logic        last;
  } result_t;
endpackage

>>> rtl/tvsd_byte_if.sv
// tvsd_byte_if: input byte channel, valid/ready
// depends on nothing
`timescale 1ns / 1ps
interface tvsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

>>> rtl/tvsd_result_if.sv
// tvsd_result_if: result channel, valid/ready
// depends on nothing
`timescale 1ns / 1ps
interface tvsd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] value;
  logic [7:0]  position;
  logic        last;
  modport source (output valid, output kind, output value, output position, output last,
                  input ready);
  modport sink (input valid, input kind, input value, input position, input last,
                output ready);
endinterface

>>> rtl/tvsd_parser.sv
// tvsd_parser: per-byte state machine producing at most one result
// depends on tvsd_pkg
`timescale 1ns / 1ps
module tvsd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output logic               res_valid_o,
  output tvsd_pkg::result_t  res_o
);
  tvsd_pkg::phase_e phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  left_m1;

  assign left_m1 = left_q - 8'd1;

  always_comb begin
    phase_d = phase_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    left_d = left_q;
    res_valid_o = 1'b0;
    res_o = '0;
    unique case (phase_q)
      tvsd_pkg::PH_INT: begin
        acc_d = {acc_q[23:0], byte_i};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          phase_d = tvsd_pkg::PH_TAG;
          cnt_d = '0;
          res_valid_o = 1'b1;
          res_o.kind = tvsd_pkg::KIND_INT;
          res_o.value = {32'd0, acc_q[23:0], byte_i};
          res_o.last = 1'b1;
        end
      end
      tvsd_pkg::PH_FLT: begin
        if (cnt_q != 3'd4) begin
          unique case (cnt_q[1:0])
            2'd0: acc_d[7:0] = byte_i;
            2'd1: acc_d[15:8] = byte_i;
            2'd2: acc_d[23:16] = byte_i;
            default: acc_d[31:24] = byte_i;
          endcase
          cnt_d = cnt_q + 3'd1;
        end else begin
          phase_d = tvsd_pkg::PH_TAG;
          cnt_d = '0;
          res_valid_o = 1'b1;
          res_o.kind = tvsd_pkg::KIND_FLT;
          res_o.last = 1'b1;
          if (byte_i != 8'd0) begin
            res_o.value = {acc_q[31], {3'd0, byte_i} + tvsd_pkg::ExpOffset,
                           acc_q[30:0], 21'd0};
          end
        end
      end
      tvsd_pkg::PH_LEN: begin
        if (byte_i == 8'd0) begin
          phase_d = tvsd_pkg::PH_TAG;
          res_valid_o = 1'b1;
          res_o.kind = tvsd_pkg::KIND_EMPTY;
          res_o.last = 1'b1;
        end else begin
          left_d = byte_i;
          phase_d = tvsd_pkg::PH_CHR;
        end
      end
      tvsd_pkg::PH_CHR: begin
        left_d = left_m1;
        res_valid_o = 1'b1;
        res_o.kind = tvsd_pkg::KIND_CHR;
        res_o.value = {56'd0, byte_i};
        res_o.position = left_m1;
        res_o.last = (left_m1 == 8'd0);
        if (left_m1 == 8'd0) phase_d = tvsd_pkg::PH_TAG;
      end
      default: begin
        acc_d = '0;
        cnt_d = '0;
        if (byte_i == tvsd_pkg::TagInt) phase_d = tvsd_pkg::PH_INT;
        else if (byte_i == tvsd_pkg::TagFlt) phase_d = tvsd_pkg::PH_FLT;
        else if (byte_i == tvsd_pkg::TagStr) phase_d = tvsd_pkg::PH_LEN;
        else begin
          phase_d = tvsd_pkg::PH_TAG;
          res_valid_o = 1'b1;
          res_o.kind = tvsd_pkg::KIND_BAD;
          res_o.last = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tvsd_pkg::PH_TAG;
      cnt_q <= '0;
      acc_q <= '0;
      left_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      left_q <= left_d;
    end
  end
endmodule

>>> rtl/tagged_value_stream_decoder.sv
// tagged_value_stream_decoder: top level, input register, parser, result register
// depends on tvsd_pkg, tvsd_byte_if, tvsd_result_if, tvsd_parser
`timescale 1ns / 1ps
// Decodes a tagged data-file byte stream (integer, five-byte float, reversed string)
// into one result per completed value, string character or bad tag. One byte is taken
// per cycle while the result side keeps up: a byte passes the input register, the
// parser state machine updates in the same cycle it leaves, and a result lands in the
// output register. Throughput is one byte per clock while the result side keeps up; a
// result is registered in the output register when its byte steps the parser.
module tagged_value_stream_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  tvsd_byte_if.sink     in_if,
  tvsd_result_if.source out_if
);
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  tvsd_pkg::result_t out_q;
  logic       step;
  logic       res_vld;
  tvsd_pkg::result_t res;
  logic       out_free;

  assign out_free = !out_vld_q || out_if.ready;
  assign step = in_vld_q && out_free;
  assign in_if.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (in_if.ready) in_vld_q <= in_if.valid;
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) in_byte_q <= in_if.stream_byte;
  end

  tvsd_parser u_parser (
    .clk_i(clk_i), .rst_ni(rst_ni), .step_i(step), .byte_i(in_byte_q),
    .res_valid_o(res_vld), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (out_free) out_vld_q <= step && res_vld;
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) out_q <= res;
  end

  assign out_if.valid = out_vld_q;
  assign out_if.kind = out_q.kind;
  assign out_if.value = out_q.value;
  assign out_if.position = out_q.position;
  assign out_if.last = out_q.last;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> out_vld_q && $stable(out_q))
    else $error("result changed while stalled");
  a_no_step_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |-> !step)
    else $error("parser stepped into a full result register");
  a_pos_only_chr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_vld && res.kind != tvsd_pkg::KIND_CHR |-> res.position == 8'd0)
    else $error("position set on a non-character result");
endmodule
